>>> sv/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
package slfd_pkg;

  // Receive phase of the frame tracker
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_t;

  // Role tag given to each byte
  typedef enum logic [2:0] {
    ROLE_IGNORED = 3'd0,
    ROLE_SYNC_A  = 3'd1,
    ROLE_SYNC_B  = 3'd2,
    ROLE_HEADER  = 3'd3,
    ROLE_PAYLOAD = 3'd4,
    ROLE_CHECK   = 3'd5,
    ROLE_DROPPED = 3'd6
  } role_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FIRST_SYNC  = 2'd0,
    REG_SECOND_SYNC = 2'd1,
    REG_MAX_LEN     = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  // Frame layout
  localparam logic [7:0] LENGTH_POS  = 8'd2;   // position of the length byte
  localparam logic [7:0] HEADER_END  = 8'd5;   // bytes up to and including header
  localparam logic [8:0] CHECK_END   = 9'd7;   // header plus two check bytes
  localparam logic [7:0] LENGTH_CAP  = 8'd248; // frame never exceeds 255 bytes

  // Register reset values
  localparam logic [7:0] FIRST_SYNC_RST  = 8'd170;
  localparam logic [7:0] SECOND_SYNC_RST = 8'd85;
  localparam logic [7:0] MAX_LEN_RST     = 8'd64;

  // Active configuration, limit already clamped
  typedef struct packed {
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    logic [7:0] limit;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic [7:0] byte_echo;
    role_t      byte_role;
    logic [7:0] frame_position;
    logic [7:0] payload_length;
    logic       frame_end;
  } result_t;

endpackage

>>> sv/sync_length_frame_deframer_core.sv
// Top level of the two-byte-sync, length-prefixed frame deframer.
// Throughput: one byte per cycle while the skid is empty; tracker steps on each byte.
// A two-entry output stage (register plus skid) keeps in_tready independent of
// out_tready, so input stalls only when both entries are full.
// Reset (rst_n low, synchronous): hunting for the first sync, counters zero,
// registers back to 170, 85 and 64, output and skid stages empty.
module sync_length_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] byte_echo, [15:8] frame_position,
                                  // [23:16] payload_length
  output logic [2:0]  out_tuser,  // [2:0] byte_role
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import slfd_pkg::*;

  cfg_t    cfg;
  result_t trk_result;
  result_t out_word;
  logic    accept;

  assign accept = in_tvalid && in_tready;

  slfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  slfd_tracker u_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (in_tdata),
    .result  (trk_result)
  );

  slfd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (trk_result),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  // Pack the result word onto the stream
  assign out_tdata = {out_word.payload_length, out_word.frame_position, out_word.byte_echo};
  assign out_tuser = out_word.byte_role;
  assign out_tlast = out_word.frame_end;

endmodule

>>> sv/slfd_cfg_regs.sv
// Configuration registers with clamped payload limit.
module slfd_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata,
  output slfd_pkg::cfg_t       cfg
);
  import slfd_pkg::*;

  logic [7:0] first_sync_r;
  logic [7:0] second_sync_r;
  logic [7:0] max_len_r;

  // Write one register per enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= FIRST_SYNC_RST;
      second_sync_r <= SECOND_SYNC_RST;
      max_len_r     <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FIRST_SYNC:  first_sync_r  <= cfg_wdata;
        REG_SECOND_SYNC: second_sync_r <= cfg_wdata;
        REG_MAX_LEN:     max_len_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the limit so a frame stays within 255 bytes
  always_comb begin
    cfg.first_sync  = first_sync_r;
    cfg.second_sync = second_sync_r;
    cfg.limit       = (max_len_r > LENGTH_CAP) ? LENGTH_CAP : max_len_r;
  end

endmodule

>>> sv/slfd_tracker.sv
// Frame phase tracker: tags each accepted byte and advances the state.
module slfd_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slfd_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output slfd_pkg::result_t    result
);
  import slfd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;

  logic [7:0] cnt_inc;
  logic [7:0] len_cur;
  logic       hdr_done;
  logic       oversize;
  logic       pay_done;
  logic       chk_done;

  // Shared decode of the current byte
  assign cnt_inc  = byte_count_r + 8'd1;
  assign len_cur  = (phase_r == PH_HEADER && byte_count_r == LENGTH_POS) ? rx_byte
                                                                         : exp_len_r;
  assign hdr_done = (cnt_inc == HEADER_END);
  assign oversize = (len_cur > cfg.limit);
  assign pay_done = ({1'b0, cnt_inc} == ({1'b0, HEADER_END} + {1'b0, exp_len_r}));
  assign chk_done = ({1'b0, cnt_inc} == (CHECK_END + {1'b0, exp_len_r}));

  // Next phase
  always_comb begin
    phase_nxt = PH_HUNT;
    unique case (phase_r)
      PH_SYNC1:   phase_nxt = (rx_byte == cfg.second_sync) ? PH_HEADER : PH_HUNT;
      PH_HEADER: begin
        if (!hdr_done)            phase_nxt = PH_HEADER;
        else if (oversize)        phase_nxt = PH_HUNT;
        else if (len_cur == 8'd0) phase_nxt = PH_CHECK;
        else                      phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: phase_nxt = pay_done ? PH_CHECK : PH_PAYLOAD;
      PH_CHECK:   phase_nxt = chk_done ? PH_HUNT : PH_CHECK;
      default:    phase_nxt = (rx_byte == cfg.first_sync) ? PH_SYNC1 : PH_HUNT;
    endcase
  end

  // Result tag and counters
  always_comb begin
    result.byte_echo      = rx_byte;
    result.byte_role      = ROLE_IGNORED;
    result.frame_position = 8'd0;
    result.payload_length = 8'd0;
    result.frame_end      = 1'b0;
    byte_count_nxt        = byte_count_r;
    exp_len_nxt           = exp_len_r;
    unique case (phase_r)
      PH_SYNC1: begin
        if (rx_byte == cfg.second_sync) begin
          result.byte_role      = ROLE_SYNC_B;
          result.frame_position = 8'd1;
          byte_count_nxt        = LENGTH_POS;
        end
      end
      PH_HEADER: begin
        result.frame_position = byte_count_r;
        result.byte_role      = ROLE_HEADER;
        byte_count_nxt        = cnt_inc;
        exp_len_nxt           = len_cur;
        if (hdr_done) begin
          result.payload_length = len_cur;
          if (oversize) result.byte_role = ROLE_DROPPED;
        end
      end
      PH_PAYLOAD: begin
        result.frame_position = byte_count_r;
        result.byte_role      = ROLE_PAYLOAD;
        result.payload_length = exp_len_r;
        byte_count_nxt        = cnt_inc;
      end
      PH_CHECK: begin
        result.frame_position = byte_count_r;
        result.byte_role      = ROLE_CHECK;
        result.payload_length = exp_len_r;
        result.frame_end      = chk_done;
        byte_count_nxt        = cnt_inc;
      end
      default: begin
        if (rx_byte == cfg.first_sync) begin
          result.byte_role = ROLE_SYNC_A;
          byte_count_nxt   = 8'd1;
        end
      end
    endcase
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      byte_count_r <= 8'd0;
      exp_len_r    <= 8'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      exp_len_r    <= exp_len_nxt;
    end
  end

endmodule

>>> sv/slfd_skid.sv
// Output register with a skid stage so the input ready never depends on out_ready directly.
module slfd_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slfd_pkg::result_t    in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slfd_pkg::result_t    out_word
);
  import slfd_pkg::*;

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_word_r;
  result_t skid_word_r;
  logic    accept;
  logic    load_out;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign load_out  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Control: drain skid first, park a word when the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r  <= skid_valid_r || accept;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r <= skid_valid_r ? skid_word_r : in_word;
    end else if (accept) begin
      skid_word_r <= in_word;
    end
  end

endmodule
